[design/rrvg_pkg.sv]
// Shared types, constants and the direction table of the rounded rectangle vertex generator.
// Used by the front end, the back end, the top level and the port checker.
package rrvg_pkg;

    localparam int MAX_SEGMENTS = 7;
    localparam int COORD_W      = 24;
    localparam int CTR_W        = 26;
    localparam int RAD_W        = 24;
    localparam int DIR_W        = 15;
    localparam int DIR_SHIFT    = 14;
    localparam int NUM_W        = 6;

    localparam logic [2:0] SQUARE_B = 3'd3;

    // Reciprocal of ten for the square-corner radius: q = (x * K) >> S.
    localparam int           DIV10_SHIFT = 28;
    localparam logic [24:0]  DIV10_K     = 25'd26843546;

    localparam logic [1:0] RING_CENTRE = 2'd0;
    localparam logic [1:0] RING_INNER  = 2'd1;
    localparam logic [1:0] RING_BORDER = 2'd2;

    localparam logic signed [26:0] COORD_MAX = 27'sd8388607;
    localparam logic signed [26:0] COORD_MIN = -27'sd8388608;

    // Row 0 is the rounded three-point set, rows 2..7 hold cos(k*pi/(2(B-1))) in Q1.14.
    localparam logic [DIR_W-1:0] DIR_TABLE [0:7][0:6] = '{
        '{15'd16384, 15'd16384, 15'd0,     15'd0,     15'd0,    15'd0,    15'd0},
        '{15'd0,     15'd0,     15'd0,     15'd0,     15'd0,    15'd0,    15'd0},
        '{15'd16384, 15'd0,     15'd0,     15'd0,     15'd0,    15'd0,    15'd0},
        '{15'd16384, 15'd11585, 15'd0,     15'd0,     15'd0,    15'd0,    15'd0},
        '{15'd16384, 15'd14189, 15'd8192,  15'd0,     15'd0,    15'd0,    15'd0},
        '{15'd16384, 15'd15137, 15'd11585, 15'd6270,  15'd0,    15'd0,    15'd0},
        '{15'd16384, 15'd15582, 15'd13255, 15'd9630,  15'd5063, 15'd0,    15'd0},
        '{15'd16384, 15'd15826, 15'd14189, 15'd11585, 15'd8192, 15'd4240, 15'd0}
    };

    typedef struct packed {
        logic signed [CTR_W-1:0] cx_lo;
        logic signed [CTR_W-1:0] cx_hi;
        logic signed [CTR_W-1:0] cy_lo;
        logic signed [CTR_W-1:0] cy_hi;
        logic [RAD_W-1:0]        rad_inner;
        logic [RAD_W-1:0]        rad_border;
        logic                    border_neg;
        logic                    border_on;
        logic                    square;
        logic [2:0]              seg_b;
    } t_job;

    function automatic logic [DIR_W-1:0] dir_value(input logic [2:0] row, input logic [2:0] idx);
        logic [DIR_W-1:0] v;
        v = '0;
        if (idx != 3'd7) begin
            v = DIR_TABLE[row][idx];
        end
        return v;
    endfunction

endpackage

[design/rrvg_queue.sv]
// Small register queue that carries prepared rectangle jobs from the front end to the back end.
// Depends on nothing but its parameters.
module rrvg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IW-1:0]    r_wr;
    logic [IW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == IW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == IW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

[design/rrvg_front.sv]
// Front end: takes one rectangle, works out radius, arc count and corner centres as a job.
// Depends on rrvg_pkg for the job type and constants.
module rrvg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [23:0]   i_rect_left,
    input  logic signed [23:0]   i_rect_top,
    input  logic [22:0]          i_rect_width,
    input  logic [22:0]          i_rect_height,
    input  logic signed [23:0]   i_corner_radius,
    input  logic [7:0]           i_segment_count,
    input  logic                 i_border_on,
    input  logic signed [23:0]   i_border_thickness,
    output logic                 o_job_valid,
    input  logic                 i_job_ready,
    output rrvg_pkg::t_job       o_job
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CALC = 2'd1;
    localparam logic [1:0] F_CTR  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic signed [23:0]  r_left;
    logic signed [23:0]  r_top;
    logic [22:0]         r_w;
    logic [22:0]         r_h;
    logic signed [23:0]  r_req;
    logic [7:0]          r_segs;
    logic                r_border;
    logic signed [23:0]  r_thick;
    logic [49:0]         r_prod;
    rrvg_pkg::t_job      r_job;
    rrvg_pkg::t_job      n_job;

    logic [22:0]         m;
    logic [24:0]         div_in;
    logic                square;
    logic [22:0]         half_m;
    logic [22:0]         rad;
    logic signed [24:0]  rb;
    logic [2:0]          seg_b;

    assign o_ready     = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = r_job;

    assign m      = (r_w < r_h) ? r_w : r_h;
    assign div_in = {1'b0, m, 1'b0} + 25'd5;
    assign half_m = {1'b0, m[22:1]};
    assign square = (r_segs < 8'd2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_CALC;
                end
            end
            F_CALC: n_state = F_CTR;
            F_CTR:  n_state = F_PUSH;
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        if (square) begin
            rad   = r_prod[rrvg_pkg::DIV10_SHIFT +: 23];
            seg_b = rrvg_pkg::SQUARE_B;
        end else begin
            if (r_req[23]) begin
                rad = '0;
            end else if (r_req[22:0] > half_m) begin
                rad = half_m;
            end else begin
                rad = r_req[22:0];
            end
            seg_b = (r_segs > 8'(rrvg_pkg::MAX_SEGMENTS)) ? 3'(rrvg_pkg::MAX_SEGMENTS)
                                                          : r_segs[2:0];
        end
        rb = signed'({2'b00, rad}) + 25'(r_thick);

        n_job.cx_lo      = 26'(r_left) + signed'({3'b000, rad});
        n_job.cx_hi      = 26'(r_left) + signed'({3'b000, r_w}) - signed'({3'b000, rad});
        n_job.cy_lo      = 26'(r_top) + signed'({3'b000, rad});
        n_job.cy_hi      = 26'(r_top) + signed'({3'b000, r_h}) - signed'({3'b000, rad});
        n_job.rad_inner  = {1'b0, rad};
        n_job.rad_border = rb[24] ? 24'(-rb) : rb[23:0];
        n_job.border_neg = rb[24];
        n_job.border_on  = r_border;
        n_job.square     = square;
        n_job.seg_b      = seg_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_left   <= i_rect_left;
            r_top    <= i_rect_top;
            r_w      <= i_rect_width;
            r_h      <= i_rect_height;
            r_req    <= i_corner_radius;
            r_segs   <= i_segment_count;
            r_border <= i_border_on;
            r_thick  <= i_border_thickness;
        end
        if (r_state == F_CALC) begin
            r_prod <= div_in * rrvg_pkg::DIV10_K;
        end
        if (r_state == F_CTR) begin
            r_job <= n_job;
        end
    end

endmodule

[design/rrvg_back.sv]
// Back end: steps through the vertices of one job and scales the directions by the radius.
// Depends on rrvg_pkg for the job type, direction table and ring codes.
module rrvg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_ready,
    input  rrvg_pkg::t_job       i_job,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [23:0]   o_x,
    output logic signed [23:0]   o_y,
    output logic [5:0]           o_num,
    output logic [1:0]           o_kind,
    output logic                 o_last
);
    rrvg_pkg::t_job     r_job;
    logic               r_active;
    logic [1:0]         r_corner;
    logic [1:0]         r_phase;
    logic [2:0]         r_k;
    logic [5:0]         r_num;

    logic               r1_valid;
    logic [38:0]        r1_px;
    logic [38:0]        r1_py;
    logic               r1_negx;
    logic               r1_negy;
    logic signed [25:0] r1_cx;
    logic signed [25:0] r1_cy;
    logic [5:0]         r1_num;
    logic [1:0]         r1_kind;
    logic               r1_last;

    logic               r_o_valid;
    logic signed [23:0] r_o_x;
    logic signed [23:0] r_o_y;
    logic [5:0]         r_o_num;
    logic [1:0]         r_o_kind;
    logic               r_o_last;

    logic               en;
    logic               issue;
    logic               arc_end;
    logic               last;
    logic [2:0]         row;
    logic [14:0]        cs;
    logic [14:0]        sn;
    logic [14:0]        magx;
    logic [14:0]        magy;
    logic [23:0]        rad;
    logic               radneg;
    logic signed [25:0] cx;
    logic signed [25:0] cy;
    logic [38:0]        sumx;
    logic [38:0]        sumy;
    logic signed [26:0] offx;
    logic signed [26:0] offy;
    logic signed [26:0] sx;
    logic signed [26:0] sy;

    assign en          = !r_o_valid || i_ready;
    assign issue       = r_active && en;
    assign o_job_ready = !r_active;

    assign arc_end = (r_phase != rrvg_pkg::RING_CENTRE) && (r_k == r_job.seg_b - 3'd1);
    assign last    = (r_corner == 2'd3) && arc_end
                     && ((r_phase == rrvg_pkg::RING_BORDER) || !r_job.border_on);

    always_comb begin
        row = r_job.square ? 3'd0 : r_job.seg_b;
        cs  = rrvg_pkg::dir_value(row, r_k);
        sn  = rrvg_pkg::dir_value(row, r_job.seg_b - 3'd1 - r_k);
        if (r_phase == rrvg_pkg::RING_CENTRE) begin
            magx = '0;
            magy = '0;
        end else if (r_corner[0] == 1'b0) begin
            magx = cs;
            magy = sn;
        end else begin
            magx = sn;
            magy = cs;
        end
        rad    = (r_phase == rrvg_pkg::RING_BORDER) ? r_job.rad_border : r_job.rad_inner;
        radneg = (r_phase == rrvg_pkg::RING_BORDER) && r_job.border_neg;
        cx     = (r_corner == 2'd1 || r_corner == 2'd2) ? r_job.cx_hi : r_job.cx_lo;
        cy     = r_corner[1] ? r_job.cy_hi : r_job.cy_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (!r_active) begin
            r_active <= i_job_valid;
        end else if (issue && last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_active) begin
            r_job    <= i_job;
            r_corner <= '0;
            r_phase  <= rrvg_pkg::RING_CENTRE;
            r_k      <= '0;
            r_num    <= '0;
        end else if (issue) begin
            r_num <= r_num + 1'b1;
            if (r_phase == rrvg_pkg::RING_CENTRE) begin
                r_phase <= rrvg_pkg::RING_INNER;
                r_k     <= '0;
            end else if (arc_end) begin
                r_k <= '0;
                if (r_phase == rrvg_pkg::RING_INNER && r_job.border_on) begin
                    r_phase <= rrvg_pkg::RING_BORDER;
                end else begin
                    r_phase  <= rrvg_pkg::RING_CENTRE;
                    r_corner <= r_corner + 1'b1;
                end
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r1_valid  <= issue;
            r_o_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px   <= magx * rad;
            r1_py   <= magy * rad;
            r1_negx <= (r_corner == 2'd0 || r_corner == 2'd3) ^ radneg;
            r1_negy <= (r_corner == 2'd0 || r_corner == 2'd1) ^ radneg;
            r1_cx   <= cx;
            r1_cy   <= cy;
            r1_num  <= r_num;
            r1_kind <= r_phase;
            r1_last <= last;
        end
    end

    always_comb begin
        sumx = r1_px + 39'd8192;
        sumy = r1_py + 39'd8192;
        offx = signed'({2'b00, sumx[38:rrvg_pkg::DIR_SHIFT]});
        offy = signed'({2'b00, sumy[38:rrvg_pkg::DIR_SHIFT]});
        sx   = r1_negx ? 27'(r1_cx) - offx : 27'(r1_cx) + offx;
        sy   = r1_negy ? 27'(r1_cy) - offy : 27'(r1_cy) + offy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (sx > rrvg_pkg::COORD_MAX) begin
                r_o_x <= rrvg_pkg::COORD_MAX[23:0];
            end else if (sx < rrvg_pkg::COORD_MIN) begin
                r_o_x <= rrvg_pkg::COORD_MIN[23:0];
            end else begin
                r_o_x <= sx[23:0];
            end
            if (sy > rrvg_pkg::COORD_MAX) begin
                r_o_y <= rrvg_pkg::COORD_MAX[23:0];
            end else if (sy < rrvg_pkg::COORD_MIN) begin
                r_o_y <= rrvg_pkg::COORD_MIN[23:0];
            end else begin
                r_o_y <= sy[23:0];
            end
            r_o_num  <= r1_num;
            r_o_kind <= r1_kind;
            r_o_last <= r1_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_x     = r_o_x;
    assign o_y     = r_o_y;
    assign o_num   = r_o_num;
    assign o_kind  = r_o_kind;
    assign o_last  = r_o_last;

endmodule

[design/rounded_rect_vertex_generator_unit.sv]
// Throughput: one vertex beat per cycle while the receiver takes them; a rectangle of B arc points
// gives 4*(1+B) vertices, or 4*(1+2B) with a border, and the back end then pauses to load the
// next job from the job queue.
// The front end takes a new rectangle only when idle, once its last job is in the job queue.
// Reset is synchronous, active low; it empties the queue and drops any rectangle in flight.
// Top level: joins the front end, the job queue and the back end. Depends on rrvg_pkg.
module rounded_rect_vertex_generator_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // rect_left, rect_top, rect_width, rect_height, corner_radius, segment_count,
    // border_on, border_thickness, one zero pad bit
    input  logic [151:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // vertex_x, vertex_y, vertex_number, two zero pad bits
    output logic [55:0]  o_m_tdata,
    // ring_kind
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast
);
    localparam int JOB_W = $bits(rrvg_pkg::t_job);

    logic               f_job_valid;
    logic               f_job_ready;
    rrvg_pkg::t_job     f_job;
    logic               q_valid;
    logic               q_ready;
    logic [JOB_W-1:0]   q_data;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [5:0]         vnum;

    rrvg_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_s_tvalid),
        .o_ready            (o_s_tready),
        .i_rect_left        (i_s_tdata[23:0]),
        .i_rect_top         (i_s_tdata[47:24]),
        .i_rect_width       (i_s_tdata[70:48]),
        .i_rect_height      (i_s_tdata[93:71]),
        .i_corner_radius    (i_s_tdata[117:94]),
        .i_segment_count    (i_s_tdata[125:118]),
        .i_border_on        (i_s_tdata[126]),
        .i_border_thickness (i_s_tdata[150:127]),
        .o_job_valid        (f_job_valid),
        .i_job_ready        (f_job_ready),
        .o_job              (f_job)
    );

    rrvg_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_job_valid),
        .o_push_ready (f_job_ready),
        .i_push_data  (f_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    rrvg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (rrvg_pkg::t_job'(q_data)),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_x         (vx),
        .o_y         (vy),
        .o_num       (vnum),
        .o_kind      (o_m_tuser),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, vnum, vy, vx};

endmodule

[design/rrvg_checker.sv]
// Port checker for the rounded rectangle vertex generator, bound to the top level.
// Depends on rrvg_pkg for the ring codes.
module rrvg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);
    logic [5:0] r_exp_num;
    logic       beat;

    assign beat = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_num <= '0;
        end else if (beat) begin
            r_exp_num <= o_m_tlast ? 6'd0 : r_exp_num + 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat changed while stalled");

    a_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat |-> o_m_tdata[53:48] == r_exp_num)
        else $error("vertex number out of sequence");

    a_first_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat && o_m_tdata[53:48] == 6'd0 |-> o_m_tuser == rrvg_pkg::RING_CENTRE)
        else $error("first vertex is not a corner centre");

    a_last_arc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat && o_m_tlast |-> o_m_tuser == rrvg_pkg::RING_INNER
                              || o_m_tuser == rrvg_pkg::RING_BORDER)
        else $error("last vertex is not an arc point");

endmodule

bind rounded_rect_vertex_generator_unit rrvg_checker u_rrvg_checker (.*);

[sim/rrvg_mesh_checker.sv]
`timescale 1ns / 1ps
// Checks the vertex stream of rounded_rect_vertex_generator_unit against its own mesh predictor.
// Watches both stream channels. Depends on rrvg_pkg for the ring kind codes.
module rrvg_mesh_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // rect_left, rect_top, rect_width, rect_height, corner_radius, segment_count,
    // border_on, border_thickness, one zero pad bit
    input  logic [151:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // vertex_x, vertex_y, vertex_number, two zero pad bits
    input  logic [55:0]  i_m_tdata,
    // ring_kind
    input  logic [1:0]   i_m_tuser,
    input  logic         i_m_tlast,
    output int           o_fails,
    output int           o_pending,
    output int           o_vertices
);

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [5:0]         num;
        logic [1:0]         ring;
        logic               last;
    } t_vertex;

    // Row B holds cos(k*pi/(2(B-1))) in Q1.14; row 0 is the rounded three-point set.
    localparam int SWEEP [0:7][0:6] = '{
        '{16384, 16384, 0,     0,     0,    0,    0},
        '{0,     0,     0,     0,     0,    0,    0},
        '{16384, 0,     0,     0,     0,    0,    0},
        '{16384, 11585, 0,     0,     0,    0,    0},
        '{16384, 14189, 8192,  0,     0,    0,    0},
        '{16384, 15137, 11585, 6270,  0,    0,    0},
        '{16384, 15582, 13255, 9630,  5063, 0,    0},
        '{16384, 15826, 14189, 11585, 8192, 4240, 0}
    };

    t_vertex expected_vertices[$];
    int      fail_total   = 0;
    int      pending_n    = 0;
    int      vertex_count = 0;

    assign o_fails    = fail_total;
    assign o_pending  = pending_n;
    assign o_vertices = vertex_count;

    function automatic logic signed [23:0] clamp_coord(longint v);
        if (v > 8388607) begin
            v = 8388607;
        end
        if (v < -8388608) begin
            v = -8388608;
        end
        return v[23:0];
    endfunction

    function automatic longint arc_offset(longint dir, longint rad);
        longint p;
        p = dir * rad;
        if (p >= 0) begin
            return (p + 8192) / 16384;
        end
        return -((-p + 8192) / 16384);
    endfunction

    function automatic void predict_mesh(input logic [151:0] beat);
        longint  left, top, w, h, req, thick, m, r, rb, rad, cs, sn, dx, dy;
        longint  cxs[4];
        longint  cys[4];
        int      b, row, segs, n, total, passes;
        t_vertex v;
        left   = $signed(beat[23:0]);
        top    = $signed(beat[47:24]);
        w      = beat[70:48];
        h      = beat[93:71];
        req    = $signed(beat[117:94]);
        segs   = beat[125:118];
        passes = beat[126] ? 2 : 1;
        thick  = $signed(beat[150:127]);
        m      = (w < h) ? w : h;
        if (segs >= 2) begin
            b   = (segs > 7) ? 7 : segs;
            row = b;
            r   = req;
            if (r > (m >>> 1)) begin
                r = m >>> 1;
            end
            if (r < 0) begin
                r = 0;
            end
        end else begin
            b   = 3;
            row = 0;
            r   = (m * 2 + 5) / 10;
        end
        rb = r + thick;
        cxs[0] = left + r;      cys[0] = top + r;
        cxs[1] = left + w - r;  cys[1] = top + r;
        cxs[2] = left + w - r;  cys[2] = top + h - r;
        cxs[3] = left + r;      cys[3] = top + h - r;
        total = 4 * (1 + b * passes);
        n = 0;
        for (int c = 0; c < 4; c++) begin
            v.x    = clamp_coord(cxs[c]);
            v.y    = clamp_coord(cys[c]);
            v.num  = n[5:0];
            v.ring = rrvg_pkg::RING_CENTRE;
            v.last = (n == total - 1);
            expected_vertices.push_back(v);
            n++;
            for (int pass = 0; pass < passes; pass++) begin
                rad = pass ? rb : r;
                for (int k = 0; k < b; k++) begin
                    cs = SWEEP[row][k];
                    sn = SWEEP[row][b - 1 - k];
                    case (c)
                        0: begin dx = -cs; dy = -sn; end
                        1: begin dx = sn;  dy = -cs; end
                        2: begin dx = cs;  dy = sn;  end
                        default: begin dx = -sn; dy = cs; end
                    endcase
                    v.x    = clamp_coord(cxs[c] + arc_offset(dx, rad));
                    v.y    = clamp_coord(cys[c] + arc_offset(dy, rad));
                    v.num  = n[5:0];
                    v.ring = pass ? rrvg_pkg::RING_BORDER : rrvg_pkg::RING_INNER;
                    v.last = (n == total - 1);
                    expected_vertices.push_back(v);
                    n++;
                end
            end
        end
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at vertex beat %0d: %s", vertex_count, what);
        fail_total++;
    endtask

    task automatic check_vertex();
        t_vertex got;
        t_vertex want;
        got.x    = i_m_tdata[23:0];
        got.y    = i_m_tdata[47:24];
        got.num  = i_m_tdata[53:48];
        got.ring = i_m_tuser;
        got.last = i_m_tlast;
        if (expected_vertices.size() == 0) begin
            flag_mismatch("vertex beat arrived with no rectangle pending");
        end else begin
            want = expected_vertices.pop_front();
            if (got.x !== want.x) begin
                flag_mismatch($sformatf("vertex_x got %0d want %0d", got.x, want.x));
            end
            if (got.y !== want.y) begin
                flag_mismatch($sformatf("vertex_y got %0d want %0d", got.y, want.y));
            end
            if (got.num !== want.num) begin
                flag_mismatch($sformatf("vertex_number got %0d want %0d", got.num, want.num));
            end
            if (got.ring !== want.ring) begin
                flag_mismatch($sformatf("ring_kind got %0d want %0d (vertex %0d)",
                                        got.ring, want.ring, want.num));
            end
            if (got.last !== want.last) begin
                flag_mismatch($sformatf("last_vertex got %0b want %0b (vertex %0d)",
                                        got.last, want.last, want.num));
            end
        end
        vertex_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                check_vertex();
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_mesh(i_s_tdata);
            end
            pending_n = expected_vertices.size();
        end
    end

    final begin
        if (expected_vertices.size() != 0) begin
            $display("%0d expected vertices never arrived", expected_vertices.size());
        end
    end

endmodule

[sim/tb_rounded_rect_vertex_generator_unit.sv]
`timescale 1ns / 1ps
// Testbench top for rounded_rect_vertex_generator_unit: clock, reset, rectangle stimulus,
// receiver back-pressure, watchdog and verdict. Depends on rrvg_mesh_checker and rrvg_pkg.
module tb_rounded_rect_vertex_generator_unit;

    localparam int RANDOM_RECTS = 450;
    localparam int STALL_CYCLES = 300;
    localparam int IDLE_LIMIT   = 3000;

    logic         i_clk;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [151:0] i_s_tdata  = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [55:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;

    int fails;
    int pending;
    int vertices;
    int idle_cycles    = 0;
    int rects_sent     = 0;
    int square_rects   = 0;
    int bordered_rects = 0;
    bit tx_steady      = 1'b0;
    bit rx_steady      = 1'b0;
    bit stall_request  = 1'b0;
    bit stall_done     = 1'b0;

    rounded_rect_vertex_generator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    rrvg_mesh_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .i_m_tlast  (o_m_tlast),
        .o_fails    (fails),
        .o_pending  (pending),
        .o_vertices (vertices)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_request && !stall_done) begin
                i_m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
                stall_done = 1'b1;
            end else begin
                i_m_tready <= rx_steady || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    function automatic logic [151:0] rect_beat(int l, int t, int w, int h, int r, int s,
                                               int b, int th);
        return {1'b0, th[23:0], b[0], s[7:0], r[23:0], h[22:0], w[22:0], t[23:0], l[23:0]};
    endfunction

    function automatic logic [151:0] random_rect();
        logic [151:0] beat;
        if ($urandom_range(0, 3) == 0) begin
            beat = rect_beat($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
        end else begin
            beat = rect_beat($urandom_range(0, 200000) - 100000,
                             $urandom_range(0, 200000) - 100000,
                             $urandom_range(0, 20000), $urandom_range(0, 20000),
                             $urandom_range(0, 12000) - 2000, $urandom_range(0, 9),
                             $urandom_range(0, 1), $urandom_range(0, 3000) - 800);
        end
        return beat;
    endfunction

    task automatic send_rect(input logic [151:0] beat);
        while (!tx_steady && $urandom_range(0, 99) < 10) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= beat;
        do @(posedge i_clk); while (!o_s_tready);
        rects_sent++;
        if (beat[125:118] < 2) begin
            square_rects++;
        end
        if (beat[126]) begin
            bordered_rects++;
        end
    endtask

    task automatic wait_for_drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_rect(rect_beat(1000, 2000, 5000, 3000, 500, 4, 0, 0));
        send_rect(rect_beat(1000, 2000, 5000, 3000, 500, 2, 1, 300));
        send_rect(rect_beat(-4000, -3000, 6000, 6000, 1200, 3, 1, -200));
        send_rect(rect_beat(0, 0, 8000, 4000, 900, 5, 1, 100));
        send_rect(rect_beat(256, 512, 3000, 9000, 700, 6, 1, 50));
        send_rect(rect_beat(-256, -512, 7000, 7000, 1500, 7, 1, -1500));
        send_rect(rect_beat(100, 100, 7000, 7000, 1500, 8, 0, 0));
        send_rect(rect_beat(100, 100, 7000, 7000, 1500, 255, 1, 64));
        send_rect(rect_beat(500, -500, 4000, 2500, 9999, 0, 0, 0));
        send_rect(rect_beat(500, -500, 4000, 2500, -50, 1, 1, 77));
        send_rect(rect_beat(0, 0, 3000, 2000, -700, 5, 1, 10));
        send_rect(rect_beat(0, 0, 3000, 2000, 1000, 4, 0, 0));
        send_rect(rect_beat(0, 0, 3001, 2001, 1001, 4, 1, 0));
        send_rect(rect_beat(0, 0, 0, 0, 500, 7, 1, 300));
        send_rect(rect_beat(0, 0, 0, 0, 0, 0, 1, 0));
        send_rect(rect_beat(8388607, -8388608, 8388607, 8388607, 8388607, 7, 1, 8388607));
        send_rect(rect_beat(-8388608, 8388607, 8388607, 8388607, -8388608, 7, 1, -8388608));
        send_rect(rect_beat(-8388608, -8388608, 8388607, 8388607, 0, 1, 1, 8388607));
        send_rect(rect_beat(-1, -1, 8388607, 8388607, -1, 255, 1, -1));
        send_rect(rect_beat(8388607, 8388607, 0, 0, 0, 0, 0, 0));
        send_rect(rect_beat(12, 34, 5, 3, 1, 2, 0, 0));
        send_rect(rect_beat(0, 0, 10, 10, 0, 1, 0, 0));
        wait_for_drain();

        for (int i = 0; i < RANDOM_RECTS; i++) begin
            tx_steady = (i < 80);
            rx_steady = (i < 80);
            if (i == 150) begin
                stall_request = 1'b1;
            end
            if (i == 300) begin
                wait_for_drain();
            end
            send_rect(random_rect());
        end
        wait_for_drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d rectangles (%0d square-corner, %0d with border), checked %0d vertices.",
                 rects_sent, square_rects, bordered_rects, vertices);
        $display("Run included a long receiver stall, drain pauses and an idle-free stretch.");
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
design/rrvg_pkg.sv
design/rrvg_queue.sv
design/rrvg_front.sv
design/rrvg_back.sv
design/rounded_rect_vertex_generator_unit.sv
design/rrvg_checker.sv
sim/rrvg_mesh_checker.sv
sim/tb_rounded_rect_vertex_generator_unit.sv
